### hw/rtl/esc_pkg.sv
// shared types, constants and the month table for the epoch to civil date converter
package esc_pkg;

    // pipeline depth: input register plus eight compute stages
    localparam int NStages = 9;

    typedef logic [NStages-1:0] stage_vec_t;

    // payload field types
    typedef logic [31:0] epoch_t;
    typedef logic [11:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  day_t;
    typedef logic [4:0]  hour_t;
    typedef logic [5:0]  minute_t;
    typedef logic [5:0]  second_t;

    // intermediate types
    typedef logic [15:0] days_t;
    typedef logic [16:0] sod_t;
    typedef logic [11:0] soh_t;
    typedef logic [2:0]  era_t;
    typedef logic [17:0] doe_t;
    typedef logic [8:0]  yoe_t;
    typedef logic [8:0]  doy_t;
    typedef logic [3:0]  mp_t;

    // t / 86400 == (t >> 7) / 675, done as a multiply by a rounded-up reciprocal
    localparam logic [25:0] DayRecip  = 26'd50903317;
    localparam int          DayShift  = 35;
    localparam logic [16:0] SecsPerDay = 17'd86400;

    // day zero moved to 0000-03-01; epoch range keeps every day in era 4 or 5
    localparam logic [19:0] ShiftDays = 20'd719468;
    localparam logic [19:0] Era4Start = 20'd584388;
    localparam logic [19:0] Era5Start = 20'd730485;
    localparam era_t        EraLow    = 3'd4;
    localparam era_t        EraHigh   = 3'd5;

    // time of day reciprocals
    localparam logic [17:0] HourRecip   = 18'd149131;
    localparam int          HourShift   = 29;
    localparam logic [16:0] SecsPerHour = 17'd3600;
    localparam logic [12:0] MinRecip    = 13'd4370;
    localparam int          MinShift    = 18;
    localparam logic [11:0] SecsPerMin  = 12'd60;

    // year of era reciprocals and boundaries
    localparam logic [18:0] Q1460Recip = 19'd367720;
    localparam int          Q1460Shift = 29;
    localparam logic [18:0] Q365Recip  = 19'd367720;
    localparam int          Q365Shift  = 27;
    localparam doe_t        Cent1Days  = 18'd36524;
    localparam doe_t        Cent2Days  = 18'd73048;
    localparam doe_t        Cent3Days  = 18'd109572;
    localparam doe_t        EraLastDay = 18'd146096;
    localparam logic [17:0] DaysPerYear = 18'd365;
    localparam yoe_t        Yoe100     = 9'd100;
    localparam yoe_t        Yoe200     = 9'd200;
    localparam yoe_t        Yoe300     = 9'd300;

    // month index from day of year
    localparam logic [11:0] MonthRecip = 12'd3427;
    localparam int          MonthShift = 19;
    localparam year_t       YearsPerEra = 12'd400;

    // first day of year of each march-based month, (153 * mp + 2) / 5
    function automatic doy_t month_start(input mp_t mp);
        doy_t res;
        case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/esc_ifs.sv
// valid/ready channel interfaces for timestamps in and calendar dates out
interface esc_in_if;
    import esc_pkg::*;

    logic   valid;
    logic   ready;
    epoch_t epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if;
    import esc_pkg::*;

    logic    valid;
    logic    ready;
    year_t   year;
    month_t  month;
    day_t    day;
    hour_t   hour;
    minute_t minute;
    second_t second;

    modport source (output valid, output year, output month, output day,
                    output hour, output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day,
                    input hour, input minute, input second, output ready);
endinterface

### hw/rtl/epoch_seconds_to_civil_date.sv
// top level: unix seconds to gregorian date and time of day, nine-stage pipeline
//
// usage
//   req carries one item per handshake: an unsigned 32-bit count of seconds since
//   1970-01-01 00:00:00. rsp returns one item per request, in order: year, month,
//   day, hour, minute and second.
//   an item is taken at a rising edge with valid and ready both high
// pipeline and throughput
//   nine register stages; an accepted item moves through stages 0 to 8 in order and
//   is offered on rsp from stage 8. one item per cycle sustained when nothing
//   stalls, set by the pipeline
// reset
//   rst_n clears the stage valid bits only; the pipeline comes up empty and
//   ready, data registers are not cleared
// stalls
//   when rsp.ready is low the output stage holds its item; earlier stages keep
//   filling bubbles, and req.ready drops only once every stage holds an item
module epoch_seconds_to_civil_date (
    input  logic             clk,
    input  logic             rst_n,
    esc_in_if.sink           req,
    esc_out_if.source        rsp
);
    import esc_pkg::*;

    stage_vec_t en;
    sod_t       sod;
    era_t       era;
    doe_t       doe;

    // handshake and per-stage load enables
    esc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .en        (en)
    );

    // days since epoch, seconds of day, era and day of era
    esc_day_split u_split (
        .clk           (clk),
        .en            (en),
        .epoch_seconds (req.epoch_seconds),
        .sod           (sod),
        .era           (era),
        .doe           (doe)
    );

    // time of day branch, delayed to line up with the date branch
    esc_tod u_tod (
        .clk    (clk),
        .en     (en),
        .sod    (sod),
        .hour   (rsp.hour),
        .minute (rsp.minute),
        .second (rsp.second)
    );

    // civil date branch
    esc_civil u_civil (
        .clk   (clk),
        .en    (en),
        .era   (era),
        .doe   (doe),
        .year  (rsp.year),
        .month (rsp.month),
        .day   (rsp.day)
    );

    // a ready receiver frees every stage, so the input side must be ready too
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.ready |-> req.ready)
        else $error("req not ready while rsp is ready");

    // date fields stay inside the calendar for every 32-bit timestamp
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.year >= 12'd1970 && rsp.year <= 12'd2106 &&
                       rsp.month >= 4'd1 && rsp.month <= 4'd12 &&
                       rsp.day >= 5'd1 && rsp.day <= 5'd31))
        else $error("date field out of range");

    // time of day fields stay inside a day
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.hour <= 5'd23 && rsp.minute <= 6'd59 &&
                       rsp.second <= 6'd59))
        else $error("time field out of range");

endmodule

### hw/rtl/esc_pipe_ctrl.sv
// stage valid bits and the backward ready chain of the converter pipeline
module esc_pipe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output esc_pkg::stage_vec_t en
);
    import esc_pkg::*;

    stage_vec_t         vld_reg;
    stage_vec_t         vld_next;
    stage_vec_t         prev_vld;
    logic [NStages:0]   rdy;

    // a stage takes new data when it is empty or its successor moves on
    always_comb
    begin
        rdy[NStages] = out_ready;
        for (int i = NStages - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign prev_vld = {vld_reg[NStages-2:0], in_valid};

    always_comb
    begin
        for (int i = 0; i < NStages; i++)
        begin
            vld_next[i] = rdy[i] ? prev_vld[i] : vld_reg[i];
        end
    end

    assign en        = rdy[NStages-1:0] & prev_vld;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NStages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

endmodule

### hw/rtl/esc_day_split.sv
// stages 0-2: day count, seconds of day, era and day of era
module esc_day_split (
    input  logic                clk,
    input  esc_pkg::stage_vec_t en,
    input  esc_pkg::epoch_t     epoch_seconds,
    output esc_pkg::sod_t       sod,
    output esc_pkg::era_t       era,
    output esc_pkg::doe_t       doe
);
    import esc_pkg::*;

    epoch_t      t0_reg;
    epoch_t      t1_reg;
    days_t       days1_reg;
    days_t       days1_next;
    sod_t        sod2_reg;
    sod_t        sod2_next;
    era_t        era2_reg;
    era_t        era2_next;
    doe_t        doe2_reg;
    doe_t        doe2_next;
    logic [50:0] day_prod;
    logic [32:0] day_secs;
    logic [19:0] z;
    logic        era_hi;

    // stage 1: days = t / 86400
    always_comb
    begin
        day_prod   = 51'(t0_reg[31:7]) * 51'(DayRecip);
        days1_next = day_prod[DayShift+15:DayShift];
    end

    // stage 2: seconds of day, shifted day count split into eras
    always_comb
    begin
        day_secs  = 33'(days1_reg) * 33'(SecsPerDay);
        sod2_next = 17'(t1_reg - day_secs[31:0]);
        z         = 20'(days1_reg) + ShiftDays;
        era_hi    = z >= Era5Start;
        era2_next = era_hi ? EraHigh : EraLow;
        doe2_next = 18'(z - (era_hi ? Era5Start : Era4Start));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t0_reg <= epoch_seconds;
        end
        if (en[1])
        begin
            t1_reg    <= t0_reg;
            days1_reg <= days1_next;
        end
        if (en[2])
        begin
            sod2_reg <= sod2_next;
            era2_reg <= era2_next;
            doe2_reg <= doe2_next;
        end
    end

    assign sod = sod2_reg;
    assign era = era2_reg;
    assign doe = doe2_reg;

endmodule

### hw/rtl/esc_tod.sv
// stages 3-8: hour, minute and second from seconds of day
module esc_tod (
    input  logic                clk,
    input  esc_pkg::stage_vec_t en,
    input  esc_pkg::sod_t       sod,
    output esc_pkg::hour_t      hour,
    output esc_pkg::minute_t    minute,
    output esc_pkg::second_t    second
);
    import esc_pkg::*;

    hour_t       hour3_reg;
    hour_t       hour3_next;
    sod_t        sod3_reg;
    soh_t        rem4_reg;
    soh_t        rem4_next;
    hour_t       hour4_reg;
    minute_t     min5_reg;
    minute_t     min5_next;
    soh_t        rem5_reg;
    hour_t       hour5_reg;
    second_t     sec6_reg;
    second_t     sec6_next;
    minute_t     min6_reg;
    hour_t       hour6_reg;
    second_t     sec7_reg;
    minute_t     min7_reg;
    hour_t       hour7_reg;
    second_t     sec8_reg;
    minute_t     min8_reg;
    hour_t       hour8_reg;
    logic [34:0] hour_prod;
    logic [16:0] hour_secs;
    logic [24:0] min_prod;
    logic [11:0] min_secs;

    always_comb
    begin
        hour_prod  = 35'(sod) * 35'(HourRecip);
        hour3_next = hour_prod[HourShift+4:HourShift];

        hour_secs  = 17'(hour3_reg) * SecsPerHour;
        rem4_next  = 12'(sod3_reg - hour_secs);

        min_prod   = 25'(rem4_reg) * 25'(MinRecip);
        min5_next  = min_prod[MinShift+5:MinShift];

        min_secs   = 12'(min5_reg) * SecsPerMin;
        sec6_next  = 6'(rem5_reg - min_secs);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            hour3_reg <= hour3_next;
            sod3_reg  <= sod;
        end
        if (en[4])
        begin
            rem4_reg  <= rem4_next;
            hour4_reg <= hour3_reg;
        end
        if (en[5])
        begin
            min5_reg  <= min5_next;
            rem5_reg  <= rem4_reg;
            hour5_reg <= hour4_reg;
        end
        if (en[6])
        begin
            sec6_reg  <= sec6_next;
            min6_reg  <= min5_reg;
            hour6_reg <= hour5_reg;
        end
        if (en[7])
        begin
            sec7_reg  <= sec6_reg;
            min7_reg  <= min6_reg;
            hour7_reg <= hour6_reg;
        end
        if (en[8])
        begin
            sec8_reg  <= sec7_reg;
            min8_reg  <= min7_reg;
            hour8_reg <= hour7_reg;
        end
    end

    assign hour   = hour8_reg;
    assign minute = min8_reg;
    assign second = sec8_reg;

endmodule

### hw/rtl/esc_civil.sv
// stages 3-8: year of era, day of year, month and final calendar date
module esc_civil (
    input  logic                clk,
    input  esc_pkg::stage_vec_t en,
    input  esc_pkg::era_t       era,
    input  esc_pkg::doe_t       doe,
    output esc_pkg::year_t      year,
    output esc_pkg::month_t     month,
    output esc_pkg::day_t       day
);
    import esc_pkg::*;

    logic [6:0]  q1460_3_reg;
    logic [6:0]  q1460_3_next;
    logic [2:0]  q36524_3_reg;
    logic [2:0]  q36524_3_next;
    logic        q146096_3_reg;
    logic        q146096_3_next;
    doe_t        doe3_reg;
    era_t        era3_reg;
    doe_t        n4_reg;
    doe_t        n4_next;
    doe_t        doe4_reg;
    era_t        era4_reg;
    yoe_t        yoe5_reg;
    yoe_t        yoe5_next;
    doe_t        doe5_reg;
    era_t        era5_reg;
    doy_t        doy6_reg;
    doy_t        doy6_next;
    yoe_t        yoe6_reg;
    era_t        era6_reg;
    mp_t         mp7_reg;
    mp_t         mp7_next;
    doy_t        doy7_reg;
    yoe_t        yoe7_reg;
    era_t        era7_reg;
    year_t       year8_reg;
    year_t       year8_next;
    month_t      month8_reg;
    month_t      month8_next;
    day_t        day8_reg;
    day_t        day8_next;
    logic [36:0] q1460_prod;
    logic [36:0] yoe_prod;
    logic [1:0]  cent;
    logic [17:0] year_days;
    logic [10:0] mp_arg;
    logic [22:0] mp_prod;
    logic        jan_feb;

    // stage 3: leap corrections of the day of era
    always_comb
    begin
        q1460_prod     = 37'(doe) * 37'(Q1460Recip);
        q1460_3_next   = q1460_prod[Q1460Shift+6:Q1460Shift];
        q36524_3_next  = 3'(doe >= Cent1Days) + 3'(doe >= Cent2Days)
                       + 3'(doe >= Cent3Days) + 3'(doe >= EraLastDay);
        q146096_3_next = doe >= EraLastDay;
    end

    // stages 4-6: year of era, then day of year
    always_comb
    begin
        n4_next   = doe3_reg - 18'(q1460_3_reg) + 18'(q36524_3_reg)
                  - 18'(q146096_3_reg);

        yoe_prod  = 37'(n4_reg) * 37'(Q365Recip);
        yoe5_next = yoe_prod[Q365Shift+8:Q365Shift];

        cent      = 2'(yoe5_reg >= Yoe100) + 2'(yoe5_reg >= Yoe200)
                  + 2'(yoe5_reg >= Yoe300);
        year_days = 18'(yoe5_reg) * DaysPerYear + 18'(yoe5_reg >> 2) - 18'(cent);
        doy6_next = 9'(doe5_reg - year_days);
    end

    // stage 7: march-based month index
    always_comb
    begin
        mp_arg   = 11'({doy6_reg, 2'b00}) + 11'(doy6_reg) + 11'd2;
        mp_prod  = 23'(mp_arg) * 23'(MonthRecip);
        mp7_next = mp_prod[MonthShift+3:MonthShift];
    end

    // stage 8: civil month, day and year; january and february roll over
    always_comb
    begin
        month8_next = (mp7_reg < 4'd10) ? mp7_reg + 4'd3 : mp7_reg - 4'd9;
        jan_feb     = month8_next <= 4'd2;
        day8_next   = 5'(doy7_reg - month_start(mp7_reg) + 9'd1);
        year8_next  = 12'(yoe7_reg) + 12'(era7_reg) * YearsPerEra + 12'(jan_feb);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            q1460_3_reg   <= q1460_3_next;
            q36524_3_reg  <= q36524_3_next;
            q146096_3_reg <= q146096_3_next;
            doe3_reg      <= doe;
            era3_reg      <= era;
        end
        if (en[4])
        begin
            n4_reg   <= n4_next;
            doe4_reg <= doe3_reg;
            era4_reg <= era3_reg;
        end
        if (en[5])
        begin
            yoe5_reg <= yoe5_next;
            doe5_reg <= doe4_reg;
            era5_reg <= era4_reg;
        end
        if (en[6])
        begin
            doy6_reg <= doy6_next;
            yoe6_reg <= yoe5_reg;
            era6_reg <= era5_reg;
        end
        if (en[7])
        begin
            mp7_reg  <= mp7_next;
            doy7_reg <= doy6_reg;
            yoe7_reg <= yoe6_reg;
            era7_reg <= era6_reg;
        end
        if (en[8])
        begin
            year8_reg  <= year8_next;
            month8_reg <= month8_next;
            day8_reg   <= day8_next;
        end
    end

    assign year  = year8_reg;
    assign month = month8_reg;
    assign day   = day8_reg;

endmodule

### test/tb_epoch_seconds_to_civil_date.sv
// self-checking testbench for the unix seconds to civil date and time converter
module tb_epoch_seconds_to_civil_date;
    timeunit 1ns;
    timeprecision 1ps;

    import esc_pkg::*;

    // calendar arithmetic constants, days shifted so day zero is 0000-03-01
    localparam int unsigned SecsInDay     = 86400;
    localparam int unsigned EpochToMarch0 = 719468;
    localparam int unsigned DaysInEra     = 146097;

    // day index of 1972-02-29, the first leap day after the epoch
    localparam int unsigned FirstLeapDay  = 789;
    localparam int unsigned DaysPerLeapCycle = 1461;
    localparam int unsigned LastDayIndex  = 49710;

    // no-progress cycles before the run is abandoned
    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 2 * NStages + 4;
    localparam int RandomPerPhase = 113;

    typedef struct packed {
        year_t   year;
        month_t  month;
        day_t    day;
        hour_t   hour;
        minute_t minute;
        second_t second;
    } civil_date_t;

    logic clk;
    logic rst_n;

    esc_in_if  req_ch();
    esc_out_if rsp_ch();

    epoch_seconds_to_civil_date u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // expected dates in acceptance order, popped as results come back
    civil_date_t dates_due[$];

    int dates_sent;
    int dates_checked;
    int mismatch_count;
    int stalled_cycles;

    // per-cycle probabilities in percent, set by each traffic phase
    int sender_idle_pct;
    int receiver_stall_pct;

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // calendar date and time of day for one timestamp, all math in 32 bits
    function automatic civil_date_t civil_date_of(epoch_t stamp);
        int unsigned days;
        int unsigned secs_of_day;
        int unsigned shifted;
        int unsigned era;
        int unsigned day_of_era;
        int unsigned year_of_era;
        int unsigned day_of_year;
        int unsigned march_month;
        int unsigned civil_month;
        int unsigned civil_year;
        civil_date_t date;
        days        = stamp / SecsInDay;
        secs_of_day = stamp - days * SecsInDay;
        shifted     = days + EpochToMarch0;
        era         = shifted / DaysInEra;
        day_of_era  = shifted - era * DaysInEra;
        // drop leap days (every fourth year, not centuries, but the 400th year)
        year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                       - day_of_era / 146096) / 365;
        day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
        march_month = (5 * day_of_year + 2) / 153;
        civil_month = (march_month < 10) ? march_month + 3 : march_month - 9;
        // january and february belong to the following civil year
        civil_year  = year_of_era + era * 400 + ((civil_month <= 2) ? 1 : 0);
        date.year   = year_t'(civil_year);
        date.month  = month_t'(civil_month);
        date.day    = day_t'(day_of_year - (153 * march_month + 2) / 5 + 1);
        date.hour   = hour_t'(secs_of_day / 3600);
        date.minute = minute_t'((secs_of_day / 60) % 60);
        date.second = second_t'(secs_of_day % 60);
        return date;
    endfunction

    // offer one timestamp, with random idle cycles ahead of it; returns at the accepting edge
    task automatic send_timestamp(input epoch_t stamp);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        req_ch.valid         <= 1'b1;
        req_ch.epoch_seconds <= stamp;
        do
            @(posedge clk);
        while (!req_ch.ready);
        dates_due.push_back(civil_date_of(stamp));
        dates_sent++;
    endtask

    // random timestamp, mostly aimed at midnight, minute, leap-day and range edges
    function automatic epoch_t pick_timestamp();
        int unsigned day_index;
        int unsigned cycle;
        case ($urandom_range(9))
            0, 1, 2:
                return epoch_t'($urandom);
            3, 4:
            begin
                // either side of midnight
                day_index = $urandom_range(LastDayIndex);
                return epoch_t'(day_index * SecsInDay + (($urandom_range(1) == 1) ? 0 : 86399)
                                - (($urandom_range(1) == 1 && day_index != 0) ? 1 : 0));
            end
            5, 6:
            begin
                // days around a leap day, the 2100 non-leap case included by the range
                cycle     = $urandom_range(32);
                day_index = FirstLeapDay + cycle * DaysPerLeapCycle + $urandom_range(2) - 1;
                return epoch_t'(day_index * SecsInDay + $urandom_range(SecsInDay - 1));
            end
            7:
                return epoch_t'($urandom_range(4000));
            8:
                return 32'hFFFF_FFFF - epoch_t'($urandom_range(4000));
            default:
                // random day, hour and minute, with the seconds at the start or end of the minute
                return epoch_t'($urandom_range(LastDayIndex - 1) * SecsInDay
                                + $urandom_range(23) * 3600 + $urandom_range(59) * 60
                                + (($urandom_range(1) == 1) ? 59 : 0));
        endcase
    endfunction

    // receiver side: ready drops at random per cycle
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

    // result checker, compares each returned date against the oldest expectation
    always @(posedge clk)
    begin
        civil_date_t want;
        civil_date_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = '{rsp_ch.year, rsp_ch.month, rsp_ch.day,
                    rsp_ch.hour, rsp_ch.minute, rsp_ch.second};
            if (dates_due.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d:%0d", $time,
                         got.year, got.month, got.day, got.hour, got.minute, got.second);
            end
            else
            begin
                want = dates_due.pop_front();
                dates_checked++;
                if (got.year != want.year)
                begin
                    mismatch_count++;
                    $display("%0t: year expected %0d actual %0d", $time, want.year, got.year);
                end
                if (got.month != want.month)
                begin
                    mismatch_count++;
                    $display("%0t: month expected %0d actual %0d", $time, want.month, got.month);
                end
                if (got.day != want.day)
                begin
                    mismatch_count++;
                    $display("%0t: day expected %0d actual %0d", $time, want.day, got.day);
                end
                if (got.hour != want.hour)
                begin
                    mismatch_count++;
                    $display("%0t: hour expected %0d actual %0d", $time, want.hour, got.hour);
                end
                if (got.minute != want.minute)
                begin
                    mismatch_count++;
                    $display("%0t: minute expected %0d actual %0d", $time,
                             want.minute, got.minute);
                end
                if (got.second != want.second)
                begin
                    mismatch_count++;
                    $display("%0t: second expected %0d actual %0d", $time,
                             want.second, got.second);
                end
            end
        end
    end

    // no-progress counter: cleared on any handshake on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // watchdog
    initial
    begin
        while (stalled_cycles < WatchdogLimit)
            @(posedge clk);
        $display("%0t: no progress for %0d cycles, %0d dates still due", $time,
                 WatchdogLimit, dates_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // epoch start, single seconds, minute, hour and day edges
    task automatic test_time_of_day_edges();
        send_timestamp(32'd0);
        send_timestamp(32'd1);
        send_timestamp(32'd59);
        send_timestamp(32'd60);
        send_timestamp(32'd3599);
        send_timestamp(32'd3600);
        send_timestamp(32'd86399);
        send_timestamp(32'd86400);
    endtask

    // year ends and leap days, including the century rules of 2000 and 2100
    task automatic test_calendar_edges();
        send_timestamp(32'd31535999);    // 1970-12-31 23:59:59
        send_timestamp(32'd31536000);    // 1971-01-01
        send_timestamp(32'd68169600);    // 1972-02-29
        send_timestamp(32'd946684799);   // end of 1999
        send_timestamp(32'd946684800);   // 2000-01-01
        send_timestamp(32'd951782400);   // 2000-02-29, leap century
        send_timestamp(32'd4107542399);  // 2100-02-28 late evening
        send_timestamp(32'd4107542400);  // 2100-03-01, no leap day in 2100
    endtask

    // full input range: signed 32-bit rollover, top of range, alternating bits
    task automatic test_input_extremes();
        send_timestamp(32'h7FFF_FFFF);
        send_timestamp(32'h8000_0000);
        send_timestamp(32'hAAAA_AAAA);
        send_timestamp(32'h5555_5555);
        send_timestamp(32'hFFFF_FFFE);
        send_timestamp(32'hFFFF_FFFF);
    endtask

    // one traffic phase of random timestamps
    task automatic test_random_stream(input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (RandomPerPhase)
            send_timestamp(pick_timestamp());
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.epoch_seconds <= '0;
        sender_idle_pct      = 0;
        receiver_stall_pct   = 0;
        dates_sent           = 0;
        dates_checked        = 0;
        mismatch_count       = 0;

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at full rate
        test_time_of_day_edges();
        test_calendar_edges();
        test_input_extremes();

        // random traffic: no idling, sender gaps, receiver stalls, then both
        test_random_stream(0, 0);
        test_random_stream(46, 0);
        test_random_stream(0, 46);
        test_random_stream(34, 34);

        req_ch.valid <= 1'b0;
        while (dates_due.size() != 0)
            @(posedge clk);
        // let any stray result surface before judging
        repeat (DrainCycles)
            @(posedge clk);

        $display("%0d timestamps sent, %0d dates checked, %0d field mismatches",
                 dates_sent, dates_checked, mismatch_count);
        $display("covered: time-of-day and leap-day edges, full 32-bit range, four traffic mixes");
        if (mismatch_count == 0 && dates_due.size() == 0 && dates_checked == dates_sent)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
hw/rtl/esc_pkg.sv
hw/rtl/esc_ifs.sv
hw/rtl/esc_pipe_ctrl.sv
hw/rtl/esc_day_split.sv
hw/rtl/esc_tod.sv
hw/rtl/esc_civil.sv
hw/rtl/epoch_seconds_to_civil_date.sv
test/tb_epoch_seconds_to_civil_date.sv
